// ===== hdl/set_assoc_cache_timing_model_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cache timing model unit
// Shared property templates for implication and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TIMING_MODEL_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_TIMING_MODEL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SACTM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SACTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sactm_pkg.sv =====
// ----------------------------------------------------------------------------
// Cache timing model package
// Fixed field widths, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package sactm_pkg;

	// Fixed port and field widths.
	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned LAT_W     = 10;
	localparam int unsigned ACC_W     = 22;
	localparam int unsigned TOT_W     = 48;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned STAMP_W   = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 10;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_POLICY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_LATENCY    = 2'd3;

	// Replacement policy codes.
	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	// Access kind codes.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_STORE = 1'b1;

	// Saturation limits.
	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_DIV    = 5'b00100,
		ST_LOOK   = 5'b01000,
		ST_UPDATE = 5'b10000
	} state_t;

	// Saturating increment of a running count.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/set_assoc_cache_timing_model_unit.sv =====
// ----------------------------------------------------------------------------
// Set-associative cache tag and timing model
// An access runs from start through the way lookups and the update state to the
// done strobe; a non-power-of-two BLOCK_BYTES or SETS adds a reciprocal multiply on one multiplier.
// The ways of the set are read from the line RAM one per clock through a single
// tag and stamp compare unit; a new transaction may start in the strobe cycle.
// After reset the line RAM is swept clear, with busy high throughout.
// ----------------------------------------------------------------------------
`default_nettype none

`include "set_assoc_cache_timing_model_unit_assert.svh"

module set_assoc_cache_timing_model_unit
	import sactm_pkg::*;
#(
	parameter int unsigned SETS        = 256,
	parameter int unsigned WAYS        = 4,
	parameter int unsigned BLOCK_BYTES = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Command channel
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 kind,
	input  wire logic [ADDR_W-1:0]    address,
	// Result channel
	output logic                      done,
	output logic                      hit,
	output logic                      evicted_dirty,
	output logic      [ACC_W-1:0]     access_cycles,
	output logic      [TOT_W-1:0]     total_cycles,
	output logic      [CNT_W-1:0]     load_count,
	output logic      [CNT_W-1:0]     store_count,
	output logic      [CNT_W-1:0]     load_hit_count,
	output logic      [CNT_W-1:0]     load_miss_count,
	output logic      [CNT_W-1:0]     store_hit_count,
	output logic      [CNT_W-1:0]     store_miss_count,
	// Configuration port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	// Geometry derived from the parameters.
	localparam int unsigned LINES   = SETS * WAYS;
	localparam int unsigned LINE_AW = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int unsigned SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned W_WORDS = BLOCK_BYTES / 4;
	localparam int unsigned WL_W    = $clog2(W_WORDS * 1023 + 1);
	localparam int unsigned COST_W  = WL_W + 2;
	localparam longint unsigned DIV_C   = longint'(BLOCK_BYTES) * longint'(SETS);
	localparam longint unsigned TAG_MAX = 64'hFFFF_FFFF / DIV_C;
	localparam int unsigned TAG_W   = $clog2(TAG_MAX + 1);
	localparam int unsigned DIV_RW  = $clog2(DIV_C) + 1;
	localparam int unsigned OFF_W   = $clog2(BLOCK_BYTES);
	localparam int unsigned TAG_SH  = OFF_W + $clog2(SETS);
	localparam bit IS_POW2 = ((BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0) &&
		((SETS & (SETS - 1)) == 0);
	localparam logic [DIV_RW:0] DVS_TAG = (DIV_RW + 1)'(DIV_C);
	localparam logic [DIV_RW:0] DVS_SET = (DIV_RW + 1)'(BLOCK_BYTES);
	// Reciprocals rounded down; the quotient estimate is at most one short.
	localparam logic [ADDR_W-1:0] MAG_TAG = ADDR_W'((64'd1 << ADDR_W) / DIV_C);
	localparam logic [ADDR_W-1:0] MAG_SET = ADDR_W'((64'd1 << ADDR_W) / BLOCK_BYTES);

	// One line of the tag store.
	typedef struct packed {
		logic               valid;
		logic               dirty;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

	// Control state.
	state_t              state_q;
	logic [LINE_AW-1:0]  clr_idx_q;
	logic [1:0]          step_q;
	logic                phase_q;
	logic [WAY_W-1:0]    issue_way_q;
	logic                issued_all_q;
	logic                rsp_vld_q;
	logic                done_q;

	// Configuration registers.
	logic                write_allocate_q;
	logic                write_back_q;
	logic                replace_policy_q;
	logic [LAT_W-1:0]    mem_latency_q;
	logic [WL_W-1:0]     wl_q;

	// Running state.
	logic [STAMP_W-1:0]  access_clock_q;
	logic [TOT_W-1:0]    cycles_total_q;
	logic [CNT_W-1:0]    loads_q;
	logic [CNT_W-1:0]    stores_q;
	logic [CNT_W-1:0]    load_hits_q;
	logic [CNT_W-1:0]    load_misses_q;
	logic [CNT_W-1:0]    store_hits_q;
	logic [CNT_W-1:0]    store_misses_q;

	// Per-transaction payload.
	logic                kind_q;
	logic [TAG_W-1:0]    tag_q;
	logic [SET_W-1:0]    set_q;
	logic [ADDR_W-1:0]   div_n_q;
	logic [DIV_RW-1:0]   rem_q;
	logic [2*ADDR_W-1:0] prod_q;
	logic [ADDR_W-1:0]   quo_q;
	logic [WAY_W-1:0]    rsp_way_q;
	logic                hit_q;
	logic [WAY_W-1:0]    hway_q;
	logic                hdirty_q;
	logic [STAMP_W-1:0]  hstamp_q;
	logic                inv_q;
	logic [WAY_W-1:0]    vway_q;
	logic                vdirty_q;
	logic [STAMP_W-1:0]  vstamp_q;
	logic                hit_out_q;
	logic                evict_q;
	logic [ACC_W-1:0]    acc_q;

	// RAM ports.
	logic                ram_we;
	logic [LINE_AW-1:0]  ram_waddr;
	line_t               ram_wdata;
	logic [LINE_AW-1:0]  ram_raddr;
	line_t               ram_rdata;

	// Combinational helpers.
	logic                accept;
	logic [TAG_W-1:0]    tag_direct;
	logic [SET_W-1:0]    set_direct;
	logic [DIV_RW:0]     div_dvs;
	logic [ADDR_W-1:0]   div_mag;
	logic [ADDR_W-1:0]   mul_a;
	logic [ADDR_W-1:0]   mul_b;
	logic [2*ADDR_W-1:0] mul_p;
	logic                div_ge;
	logic [DIV_RW-1:0]   rem_next;
	logic [ADDR_W-1:0]   quot_next;
	logic [LINE_AW-1:0]  set_base;
	logic                is_store;
	logic                fill;
	logic                around;
	logic                wb;
	logic                add_l;
	logic [COST_W-1:0]   cost;
	logic [TOT_W:0]      tot_sum;
	logic                tag_match;
	logic                stamp_lt;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Direct address split when both geometry constants are powers of two.
	assign tag_direct = TAG_W'(address >> TAG_SH);
	assign set_direct = (SETS == 1) ? '0 : SET_W'(address >> OFF_W);

	// Shared 32 by 32 multiplier for the reciprocal division, and the final
	// compare and subtract that brings the quotient up by one where needed.
	always_comb begin
		div_dvs   = phase_q ? DVS_SET : DVS_TAG;
		div_mag   = phase_q ? MAG_SET : MAG_TAG;
		mul_a     = (step_q == '0) ? div_n_q : prod_q[2*ADDR_W-1:ADDR_W];
		mul_b     = (step_q == '0) ? div_mag : ADDR_W'(div_dvs);
		mul_p     = (2*ADDR_W)'(mul_a) * (2*ADDR_W)'(mul_b);
		div_ge    = ({1'b0, rem_q} >= div_dvs);
		rem_next  = div_ge ? DIV_RW'({1'b0, rem_q} - div_dvs) : rem_q;
		quot_next = div_ge ? quo_q + 1'b1 : quo_q;
	end

	// First line of the set and the shared tag and stamp compare unit.
	assign set_base  = LINE_AW'(LINE_AW'(set_q) * LINE_AW'(WAYS));
	assign tag_match = ram_rdata.valid && (ram_rdata.tag == tag_q);
	assign stamp_lt  = (ram_rdata.stamp < vstamp_q);

	// Outcome and cost of the transaction, evaluated in the update cycle.
	always_comb begin
		is_store = (kind_q == KIND_STORE);
		fill     = !hit_q && (!is_store || write_allocate_q);
		around   = !hit_q && is_store && !write_allocate_q;
		wb       = fill && !inv_q && vdirty_q;
		add_l    = (is_store && !write_back_q && (hit_q || fill)) || around;
		cost     = COST_W'(1)
			+ ((fill || around) ? COST_W'(wl_q) : '0)
			+ (add_l ? COST_W'(mem_latency_q) : '0)
			+ (wb ? COST_W'(wl_q) : '0);
		tot_sum  = {1'b0, cycles_total_q} + (TOT_W + 1)'(cost);
	end

	// RAM access: clearing sweep, way lookups and the line update.
	always_comb begin
		ram_raddr = set_base + LINE_AW'(issue_way_q);
		ram_we    = 1'b0;
		ram_waddr = clr_idx_q;
		ram_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_UPDATE: begin
				if (hit_q) begin
					ram_we          = 1'b1;
					ram_waddr       = set_base + LINE_AW'(hway_q);
					ram_wdata.valid = 1'b1;
					ram_wdata.dirty = (is_store && write_back_q) ? 1'b1 : hdirty_q;
					ram_wdata.tag   = tag_q;
					ram_wdata.stamp = (replace_policy_q == POLICY_LRU) ? access_clock_q
						: hstamp_q;
				end else if (fill) begin
					ram_we          = 1'b1;
					ram_waddr       = set_base + LINE_AW'(vway_q);
					ram_wdata.valid = 1'b1;
					ram_wdata.dirty = is_store && write_back_q;
					ram_wdata.tag   = tag_q;
					ram_wdata.stamp = access_clock_q;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	sactm_ram #(
		.WIDTH ($bits(line_t)),
		.DEPTH (LINES)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Configuration registers and the memory cost of one block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_allocate_q <= 1'b1;
			write_back_q     <= 1'b1;
			replace_policy_q <= POLICY_LRU;
			mem_latency_q    <= LAT_W'(100);
			wl_q             <= WL_W'(W_WORDS * 100);
		end else begin
			wl_q <= WL_W'(WL_W'(mem_latency_q) * WL_W'(W_WORDS));
			if (cfg_we) begin
				case (cfg_index)
					CFG_WRITE_ALLOCATE: write_allocate_q <= cfg_wdata[0];
					CFG_WRITE_BACK:     write_back_q     <= cfg_wdata[0];
					CFG_REPLACE_POLICY: replace_policy_q <= cfg_wdata[0];
					CFG_MEM_LATENCY:    mem_latency_q    <= cfg_wdata;
					default: begin
					end
				endcase
			end
		end
	end

	// Sequencer, running totals and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_idx_q      <= '0;
			step_q         <= '0;
			phase_q        <= 1'b0;
			issue_way_q    <= '0;
			issued_all_q   <= 1'b0;
			rsp_vld_q      <= 1'b0;
			done_q         <= 1'b0;
			access_clock_q <= '0;
			cycles_total_q <= '0;
			loads_q        <= '0;
			stores_q       <= '0;
			load_hits_q    <= '0;
			load_misses_q  <= '0;
			store_hits_q   <= '0;
			store_misses_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LINE_AW'(LINES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						step_q       <= '0;
						phase_q      <= 1'b0;
						issue_way_q  <= '0;
						issued_all_q <= 1'b0;
						rsp_vld_q    <= 1'b0;
						state_q      <= IS_POW2 ? ST_LOOK : ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (&step_q) begin
						phase_q <= 1'b1;
						if (phase_q) begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					// Issue one way read a cycle; the registered read data returns in the next cycle.
					rsp_vld_q <= !issued_all_q;
					if (!issued_all_q) begin
						if (issue_way_q == WAY_W'(WAYS - 1)) begin
							issued_all_q <= 1'b1;
						end else begin
							issue_way_q <= issue_way_q + 1'b1;
						end
					end
					if (rsp_vld_q && (rsp_way_q == WAY_W'(WAYS - 1))) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					done_q         <= 1'b1;
					state_q        <= ST_IDLE;
					access_clock_q <= access_clock_q + 1'b1;
					cycles_total_q <= tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
					if (is_store) begin
						stores_q <= sat_inc(stores_q);
						if (hit_q) begin
							store_hits_q <= sat_inc(store_hits_q);
						end else begin
							store_misses_q <= sat_inc(store_misses_q);
						end
					end else begin
						loads_q <= sat_inc(loads_q);
						if (hit_q) begin
							load_hits_q <= sat_inc(load_hits_q);
						end else begin
							load_misses_q <= sat_inc(load_misses_q);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Transaction payload: address split, way search and result values.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q  <= kind;
					tag_q   <= tag_direct;
					set_q   <= set_direct;
					div_n_q <= address;
					rem_q   <= '0;
					hit_q   <= 1'b0;
					inv_q   <= 1'b0;
				end
			end
			ST_DIV: begin
				// Tag is the quotient by the set span; set is the remainder divided by the block size.
				case (step_q)
					2'd0: begin
						prod_q <= mul_p;
					end
					2'd1: begin
						// Estimated quotient, then multiplied back by the divisor.
						quo_q  <= prod_q[2*ADDR_W-1:ADDR_W];
						prod_q <= mul_p;
					end
					2'd2: begin
						rem_q <= DIV_RW'(div_n_q - prod_q[ADDR_W-1:0]);
					end
					default: begin
						if (phase_q) begin
							set_q <= SET_W'(quot_next);
						end else begin
							tag_q   <= TAG_W'(quot_next);
							div_n_q <= ADDR_W'(rem_next);
						end
					end
				endcase
			end
			ST_LOOK: begin
				rsp_way_q <= issue_way_q;
				if (rsp_vld_q) begin
					// First valid tag match is the hit way.
					if (!hit_q && tag_match) begin
						hit_q    <= 1'b1;
						hway_q   <= rsp_way_q;
						hdirty_q <= ram_rdata.dirty;
						hstamp_q <= ram_rdata.stamp;
					end
					// Victim: first invalid way, else the oldest stamp, lowest way on a tie.
					if (!inv_q) begin
						if (!ram_rdata.valid) begin
							inv_q    <= 1'b1;
							vway_q   <= rsp_way_q;
							vdirty_q <= 1'b0;
						end else if ((rsp_way_q == '0) || stamp_lt) begin
							vway_q   <= rsp_way_q;
							vdirty_q <= ram_rdata.dirty;
							vstamp_q <= ram_rdata.stamp;
						end
					end
				end
			end
			ST_UPDATE: begin
				hit_out_q <= hit_q;
				evict_q   <= wb;
				acc_q     <= (32'(cost) > 32'(ACC_MAX)) ? ACC_MAX : ACC_W'(cost);
			end
			default: begin
			end
		endcase
	end

	// Result ports.
	assign done             = done_q;
	assign hit              = hit_out_q;
	assign evicted_dirty    = evict_q;
	assign access_cycles    = acc_q;
	assign total_cycles     = cycles_total_q;
	assign load_count       = loads_q;
	assign store_count      = stores_q;
	assign load_hit_count   = load_hits_q;
	assign load_miss_count  = load_misses_q;
	assign store_hit_count  = store_hits_q;
	assign store_miss_count = store_misses_q;

	// Assertions.
	`SACTM_ASSERT_IMPL(a_done_after_update, clk, arst_n, done_q, $past(state_q == ST_UPDATE), "result strobe without an update cycle")
	`SACTM_ASSERT_NEXT(a_busy_after_start, clk, arst_n, accept, busy, "accepted transaction did not raise busy")
	`SACTM_ASSERT_IMPL(a_no_evict_on_hit, clk, arst_n, done_q, !(hit_out_q && evict_q), "dirty eviction reported on a hit")
	`SACTM_ASSERT_NEXT(a_total_monotonic, clk, arst_n, 1'b1, cycles_total_q >= $past(cycles_total_q), "cycle total decreased")

endmodule

`default_nettype wire

// ===== hdl/sactm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sactm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
